/* rtl/ucb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ucb_pkg
// Shared types and constants of the UCB1 arm selector.
// ----------------------------------------------------------------------------
package ucb_pkg;
  localparam int NUM_ARMS = 8;
  localparam int COUNT_BITS = 32;
  localparam int ARM_BITS = (NUM_ARMS > 1) ? $clog2(NUM_ARMS) : 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [15:0] GAIN_RESET = 16'd5793;

  typedef struct packed {
    logic [2:0] arm;
    logic       success;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  next_arm;
    logic [31:0] arm_attempts;
    logic [31:0] arm_successes;
  } out_beat_t;
endpackage
`default_nettype wire

/* rtl/ucb1_bandit_arm_selector.sv */
`default_nettype none
// the result waits on the bit-serial log, dividers and square root for each arm once
// every arm is tried; the search ends early at the first untried arm
// throughput: one beat at a time, in_stall high until the result is taken
// reset: synchronous, clears all counts, total and sets gain to its default
// ----------------------------------------------------------------------------
// ucb1_bandit_arm_selector
// Per-arm counts and UCB1 choice of the next arm; one shift/subtract divider,
// shared by both divisions, and a bit-serial square root under a small sequencer.
// ----------------------------------------------------------------------------
module ucb1_bandit_arm_selector (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_we,
  input  wire [15:0]           cfg_wdata,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire ucb_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output ucb_pkg::out_beat_t   out_data
);
  import ucb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LOGM, S_LN, S_ARM, S_DIVM, S_DIVR, S_SQRT, S_SCORE, S_DONE
  } state_t;

  state_t state;
  logic [COUNT_BITS-1:0] att [NUM_ARMS];
  logic [COUNT_BITS-1:0] suc [NUM_ARMS];
  logic [COUNT_BITS-1:0] total;
  logic [15:0] gain;
  logic [ARM_BITS-1:0] idx, best;
  logic [63:0] best_score;
  logic [4:0] e;
  logic [32:0] m;
  logic [15:0] frac;
  logic [21:0] ln_q;
  logic [6:0] cnt;
  logic [63:0] quo, rem, acc;
  logic [63:0] mean;
  logic [63:0] root, sq_bit;
  logic [COUNT_BITS-1:0] cur_att, cur_suc;
  logic [COUNT_BITS-1:0] att_next, suc_next;
  logic [65:0] msq;
  logic [64:0] rem_sh;
  logic div_ge;
  logic [63:0] quo_next;
  logic [63:0] trial;
  logic [53:0] ln_prod;
  logic [47:0] sc_prod;
  logic [63:0] score;
  logic [4:0] top;

  assign in_stall = (state != S_IDLE);
  assign cur_att = att[idx];
  assign cur_suc = suc[idx];
  assign msq = {33'd0, m} * {33'd0, m};
  assign rem_sh = {rem, quo[63]};
  assign div_ge = (rem_sh >= {33'd0, cur_att});
  assign quo_next = {quo[62:0], div_ge};
  assign trial = root + sq_bit;
  assign ln_prod = {16'd0, e, frac} * {22'd0, LN2_Q32} >> 32;
  assign sc_prod = {32'd0, gain} * root[31:0];
  assign score = mean + {28'd0, sc_prod[47:12]};

  always_comb begin
    top = '0;
    for (int k = 0; k < 32; k++) if (total[k]) top = 5'(k);
  end

  always_comb begin
    att_next = att[ARM_BITS'(in_data.arm)];
    suc_next = suc[ARM_BITS'(in_data.arm)];
    if (att_next != COUNT_MAX) att_next = att_next + 1'b1;
    if (in_data.success && suc_next != COUNT_MAX) suc_next = suc_next + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      total <= '0;
      gain <= GAIN_RESET;
      for (int i = 0; i < NUM_ARMS; i++) begin
        att[i] <= '0;
        suc[i] <= '0;
      end
    end else begin
      if (cfg_we) gain <= cfg_wdata;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (32'(in_data.arm) < NUM_ARMS) begin
              att[ARM_BITS'(in_data.arm)] <= att_next;
              suc[ARM_BITS'(in_data.arm)] <= suc_next;
              if (total != COUNT_MAX) total <= total + 1'b1;
              out_data.arm_attempts <= 32'(att_next);
              out_data.arm_successes <= 32'(suc_next);
            end else begin
              out_data.arm_attempts <= '0;
              out_data.arm_successes <= '0;
            end
            idx <= '0;
            best <= '0;
            state <= S_ARM;
            cnt <= '0;
          end
        end
        S_ARM: begin
          // first pass finds untried arms, later passes score them
          if (cnt == 7'd0) begin
            if (total == '0) begin
              best <= '0;
              state <= S_DONE;
            end else if (cur_att == '0) begin
              best <= idx;
              state <= S_DONE;
            end else if (32'(idx) == NUM_ARMS - 1) begin
              e <= top;
              m <= 33'({32'd0, total} << (5'd31 - top));
              frac <= '0;
              cnt <= '0;
              state <= S_LOGM;
            end else begin
              idx <= idx + 1'b1;
            end
          end else begin
            quo <= {16'd0, cur_suc, 16'd0};
            rem <= '0;
            cnt <= '0;
            state <= S_DIVM;
          end
        end
        S_LOGM: begin
          if (msq[65:31] >= 35'h1_0000_0000) begin
            frac <= {frac[14:0], 1'b1};
            m <= 33'(msq[65:32]);
          end else begin
            frac <= {frac[14:0], 1'b0};
            m <= 33'(msq[65:31]);
          end
          cnt <= cnt + 1'b1;
          if (cnt == 7'd15) state <= S_LN;
        end
        S_LN: begin
          ln_q <= ln_prod[21:0];
          idx <= '0;
          best_score <= '0;
          cnt <= 7'd1;
          state <= S_ARM;
        end
        S_DIVM, S_DIVR: begin
          // restoring division, one quotient bit per cycle
          if (cnt != 7'd63) begin
            if (div_ge) begin
              rem <= 64'(rem_sh - {33'd0, cur_att});
            end else begin
              rem <= rem_sh[63:0];
            end
            quo <= quo_next;
            cnt <= cnt + 1'b1;
          end else begin
            cnt <= '0;
            if (state == S_DIVM) begin
              mean <= (quo_next > 64'hFFFF) ? 64'hFFFF : quo_next;
              quo <= {26'd0, ln_q, 16'd0};
              rem <= '0;
              state <= S_DIVR;
            end else begin
              acc <= quo_next;
              root <= '0;
              sq_bit <= 64'd1 << 62;
              state <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          if (acc >= trial) begin
            acc <= acc - trial;
            root <= (root >> 1) + sq_bit;
          end else begin
            root <= root >> 1;
          end
          sq_bit <= sq_bit >> 2;
          cnt <= cnt + 1'b1;
          if (cnt == 7'd31) state <= S_SCORE;
        end
        S_SCORE: begin
          if (idx == '0 || score > best_score) begin
            best_score <= score;
            best <= idx;
          end
          if (32'(idx) == NUM_ARMS - 1) begin
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
            cnt <= 7'd1;
            state <= S_ARM;
          end
        end
        S_DONE: begin
          if (!out_valid) begin
            out_data.next_arm <= 3'(best);
            out_valid <= 1'b1;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* tb/sv/ucb_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ucb_checker
// Watches the config port and both beat channels of the UCB1 arm selector,
// keeps its own copy of the arm counts, total and gain, predicts every result
// beat and compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
module ucb_checker (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_we,
  input  wire [15:0]          cfg_wdata,
  input  wire                 in_valid,
  input  wire                 in_stall,
  input  ucb_pkg::in_beat_t   in_data,
  input  wire                 out_valid,
  input  wire                 out_stall,
  input  ucb_pkg::out_beat_t  out_data,
  output int                  errors,
  output int                  pending
);
  import ucb_pkg::*;

  logic [31:0] att_cnt [NUM_ARMS];
  logic [31:0] suc_cnt [NUM_ARMS];
  logic [31:0] total_cnt;
  logic [15:0] gain;
  out_beat_t   expected_beats[$];

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == COUNT_MAX) ? v : v + 32'd1;
  endfunction

  function automatic logic [63:0] log2_fix(input logic [31:0] t);
    int          e;
    logic [63:0] m;
    logic [63:0] frac;
    e = 0;
    frac = '0;
    for (int k = 0; k < 32; k++) if (t[k]) e = k;
    m = 64'(t) << (31 - e);
    for (int k = 0; k < 16; k++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return (64'(e) << 16) | frac;
  endfunction

  function automatic logic [63:0] sqrt_fix(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] arm_score(input logic [31:0] att, input logic [31:0] suc,
                                            input logic [63:0] ln_q16);
    logic [63:0] mean;
    logic [63:0] root;
    if (att == 0) return '0;
    mean = (64'(suc) << 16) / 64'(att);
    if (mean > 64'hFFFF) mean = 64'hFFFF;
    root = sqrt_fix((ln_q16 << 16) / 64'(att));
    return mean + ((64'(gain) * root) >> 12);
  endfunction

  function automatic logic [2:0] pick_arm();
    logic [63:0] ln_q16;
    logic [63:0] best_s;
    logic [63:0] s;
    int          best;
    if (total_cnt == 0) return '0;
    for (int i = 0; i < NUM_ARMS; i++) if (att_cnt[i] == 0) return 3'(i);
    ln_q16 = (log2_fix(total_cnt) * 64'(LN2_Q32)) >> 32;
    best = 0;
    best_s = arm_score(att_cnt[0], suc_cnt[0], ln_q16);
    for (int i = 1; i < NUM_ARMS; i++) begin
      s = arm_score(att_cnt[i], suc_cnt[i], ln_q16);
      if (s > best_s) begin
        best_s = s;
        best = i;
      end
    end
    return 3'(best);
  endfunction

  always @(posedge clk) begin
    out_beat_t exp_b;
    if (rst) begin
      for (int i = 0; i < NUM_ARMS; i++) begin
        att_cnt[i] = '0;
        suc_cnt[i] = '0;
      end
      total_cnt = '0;
      gain = GAIN_RESET;
      expected_beats.delete();
      errors = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with no expectation waiting");
          errors++;
        end else begin
          exp_b = expected_beats.pop_front();
          if (out_data.next_arm !== exp_b.next_arm) begin
            $error("next_arm expected %0d actual %0d", exp_b.next_arm, out_data.next_arm);
            errors++;
          end
          if (out_data.arm_attempts !== exp_b.arm_attempts) begin
            $error("arm_attempts expected %0d actual %0d",
                   exp_b.arm_attempts, out_data.arm_attempts);
            errors++;
          end
          if (out_data.arm_successes !== exp_b.arm_successes) begin
            $error("arm_successes expected %0d actual %0d",
                   exp_b.arm_successes, out_data.arm_successes);
            errors++;
          end
        end
      end
      if (cfg_we) gain = cfg_wdata;
      if (in_valid && !in_stall) begin
        exp_b = '0;
        if (int'(in_data.arm) < NUM_ARMS) begin
          att_cnt[in_data.arm] = sat_inc(att_cnt[in_data.arm]);
          if (in_data.success) suc_cnt[in_data.arm] = sat_inc(suc_cnt[in_data.arm]);
          total_cnt = sat_inc(total_cnt);
          exp_b.arm_attempts = att_cnt[in_data.arm];
          exp_b.arm_successes = suc_cnt[in_data.arm];
        end
        exp_b.next_arm = pick_arm();
        expected_beats.push_back(exp_b);
      end
    end
    pending = expected_beats.size();
  end
endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives outcome beats and gain writes into the UCB1 arm selector under
// varying idle and stall patterns, with one long receiver hold-off; the
// checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import ucb_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE = 1200;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [15:0] cfg_wdata;
  logic       in_valid;
  logic       in_stall;
  in_beat_t   in_data;
  logic       out_valid;
  logic       out_stall;
  out_beat_t  out_data;
  int         errors;
  int         pending;
  int         cycles;
  int         idle_pct;
  int         stall_pct;
  logic       hold_go;
  logic       hold_used;
  int         hold_cnt;
  logic [2:0] last_next;
  int         beats_sent;
  int         win_pct [NUM_ARMS];

  ucb1_bandit_arm_selector dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  ucb_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver side, with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_cnt <= 0;
      hold_used <= 1'b0;
    end else if (hold_go && !hold_used) begin
      out_stall <= 1'b1;
      hold_cnt <= 3000;
      hold_used <= 1'b1;
    end else if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
    if (out_valid && !out_stall) last_next <= out_data.next_arm;
  end

  task automatic send_beat(input logic [2:0] a, input logic s);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{arm: a, success: s};
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  task automatic write_gain(input logic [15:0] g);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_beats(input int n);
    logic [2:0] a;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 60) a = last_next;
      else a = 3'($urandom_range(NUM_ARMS - 1));
      send_beat(a, $urandom_range(99) < win_pct[a]);
    end
  endtask

  initial begin
    logic [15:0] gains [4];
    cycles = 0;
    beats_sent = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_go = 1'b0;
    last_next = '0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: default gain, untried arms, both outcomes on every arm
    send_beat(3'd0, 1'b0);
    send_beat(3'd0, 1'b1);
    for (int a = 1; a < NUM_ARMS; a++) send_beat(3'(a), a[0]);
    for (int a = NUM_ARMS - 1; a >= 0; a--) send_beat(3'(a), ~a[0]);
    send_beat(3'd7, 1'b1);
    send_beat(3'd7, 1'b1);

    gains[0] = 16'd0;
    gains[1] = 16'hFFFF;
    gains[2] = 16'($urandom_range(1, 16'hFFFE));
    gains[3] = GAIN_RESET;
    for (int p = 0; p < 4; p++) begin
      write_gain(gains[p]);
      for (int a = 0; a < NUM_ARMS; a++) win_pct[a] = $urandom_range(100);
      case (p)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 45; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 45; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      if (p == 2) hold_go = 1'b1;
      random_beats(95);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("run covered %0d outcome beats over four gain settings incl 0 and max,", beats_sent);
    $display("with idle, stall, mixed and long hold-off traffic phases");
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

/* sim.f */
rtl/ucb_pkg.sv
rtl/ucb1_bandit_arm_selector.sv
tb/sv/ucb_checker.sv
tb/sv/tb_top.sv
